// ----- hdl/scpt_pkg.sv -----
// Shared types and constants for the sorted control point table.
package scpt_pkg;
   localparam int MaxPoints = 16;
   localparam int IdxW = $clog2(MaxPoints);
   localparam int CntW = $clog2(MaxPoints + 1);
   localparam logic [15:0] MidGray = 16'h8000;

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BAD_SLOT = 2'd2;

   typedef struct packed {
      logic load;
      logic scan;
      logic shift_up;
      logic shift_down;
      logic div_start;
      logic div_step;
      logic blend_mul;
      logic blend_sum;
      logic write_new;
      logic gray;
      logic copy_lo;
      logic copy_hi;
      logic cnt_inc;
      logic cnt_dec;
   } ctl_type;

   typedef struct packed {
      logic is_remove;
      logic empty;
      logic full;
      logic bad_slot;
      logic scan_done;
      logic shift_done;
      logic div_done;
      logic at_front;
      logic at_end;
   } sts_type;
endpackage

// ----- hdl/scpt_datapath.sv -----
// Datapath of the sorted control point table: entry store, search, shifts, divider and blend.
module scpt_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  scpt_pkg::ctl_type            ctl,
   output scpt_pkg::sts_type            sts,
   input  logic                         req_op,
   input  logic [15:0]                  req_point_value,
   input  logic [15:0]                  req_point_opacity,
   input  logic [3:0]                   req_slot_index,
   output logic [scpt_pkg::IdxW-1:0]    slot_out,
   output logic [scpt_pkg::CntW-1:0]    count_out,
   output logic [15:0]                  red_out,
   output logic [15:0]                  green_out,
   output logic [15:0]                  blue_out
);
   localparam int N = scpt_pkg::MaxPoints;
   localparam int IW = scpt_pkg::IdxW;
   localparam int CW = scpt_pkg::CntW;

   logic [15:0] pos_ff [N];
   logic [15:0] red_ff [N];
   logic [15:0] grn_ff [N];
   logic [15:0] blu_ff [N];
   logic [15:0] opa_ff [N];

   logic          op_ff;
   logic [15:0]   val_ff, opa_in_ff;
   logic [3:0]    idx_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] slot_ff, slot_in;
   logic          found_ff, found_in;
   logic [15:0]   rem_ff, rem_in;
   logic [15:0]   den_ff, quo_ff, quo_in;
   logic [4:0]    dcnt_ff, dcnt_in;
   logic [15:0]   r0_ff, r1_ff, g0_ff, g1_ff, b0_ff, b1_ff;
   logic [32:0]   pr0_ff, pr1_ff, pg0_ff, pg1_ff, pb0_ff, pb1_ff;
   logic [15:0]   ro_ff, go_ff, bo_ff, ro_in, go_in, bo_in;

   logic [IW-1:0] ptr_ix, slot_ix, slot_m1;
   logic [17:0]   trial;
   logic [16:0]   tc;

   assign ptr_ix = ptr_ff[IW-1:0];
   assign slot_ix = slot_ff[IW-1:0];
   assign slot_m1 = slot_ix - IW'(1);
   assign trial = {1'b0, rem_ff, 1'b0} - {2'b00, den_ff};
   assign tc = 17'h10000 - {1'b0, quo_ff};

   always_comb begin
      cnt_in = cnt_ff;
      if (ctl.cnt_inc) cnt_in = cnt_ff + CW'(1);
      else if (ctl.cnt_dec) cnt_in = cnt_ff - CW'(1);
      ptr_in = ptr_ff;
      slot_in = slot_ff;
      found_in = found_ff;
      if (ctl.load) begin
         ptr_in = (req_op == scpt_pkg::OP_REMOVE) ? CW'(req_slot_index) : '0;
         found_in = 1'b0;
         slot_in = '0;
      end else if (ctl.scan) begin
         if (!found_ff) begin
            if (ptr_ff == cnt_ff) begin
               found_in = 1'b1;
               slot_in = ptr_ff;
            end else if (pos_ff[ptr_ix] > val_ff) begin
               found_in = 1'b1;
               slot_in = ptr_ff;
            end else begin
               ptr_in = ptr_ff + CW'(1);
            end
         end else begin
            ptr_in = cnt_ff;
         end
      end else if (ctl.shift_up) begin
         ptr_in = ptr_ff - CW'(1);
      end else if (ctl.shift_down) begin
         ptr_in = ptr_ff + CW'(1);
      end
      rem_in = rem_ff;
      quo_in = quo_ff;
      dcnt_in = dcnt_ff;
      if (ctl.div_start) begin
         rem_in = val_ff - pos_ff[slot_m1];
         quo_in = '0;
         dcnt_in = 5'd16;
      end else if (ctl.div_step) begin
         if (!trial[17]) rem_in = trial[15:0];
         else rem_in = {rem_ff[14:0], 1'b0};
         quo_in = {quo_ff[14:0], ~trial[17]};
         dcnt_in = dcnt_ff - 5'd1;
      end
      ro_in = ro_ff; go_in = go_ff; bo_in = bo_ff;
      if (ctl.load) begin
         ro_in = '0; go_in = '0; bo_in = '0;
      end else if (ctl.gray) begin
         ro_in = scpt_pkg::MidGray; go_in = scpt_pkg::MidGray; bo_in = scpt_pkg::MidGray;
      end else if (ctl.copy_lo) begin
         ro_in = red_ff[0]; go_in = grn_ff[0]; bo_in = blu_ff[0];
      end else if (ctl.copy_hi) begin
         ro_in = red_ff[slot_m1]; go_in = grn_ff[slot_m1]; bo_in = blu_ff[slot_m1];
      end else if (ctl.blend_sum) begin
         ro_in = 16'((pr0_ff + pr1_ff) >> 16);
         go_in = 16'((pg0_ff + pg1_ff) >> 16);
         bo_in = 16'((pb0_ff + pb1_ff) >> 16);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      ptr_ff <= ptr_in;
      slot_ff <= slot_in;
      found_ff <= found_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dcnt_ff <= dcnt_in;
      ro_ff <= ro_in;
      go_ff <= go_in;
      bo_ff <= bo_in;
      if (ctl.load) begin
         op_ff <= req_op;
         val_ff <= req_point_value;
         opa_in_ff <= req_point_opacity;
         idx_ff <= req_slot_index;
      end
      if (ctl.div_start) begin
         den_ff <= pos_ff[slot_ix] - pos_ff[slot_m1];
         r0_ff <= red_ff[slot_m1]; r1_ff <= red_ff[slot_ix];
         g0_ff <= grn_ff[slot_m1]; g1_ff <= grn_ff[slot_ix];
         b0_ff <= blu_ff[slot_m1]; b1_ff <= blu_ff[slot_ix];
      end
      if (ctl.blend_mul) begin
         pr0_ff <= 33'(r0_ff * tc); pr1_ff <= 33'(r1_ff * quo_ff);
         pg0_ff <= 33'(g0_ff * tc); pg1_ff <= 33'(g1_ff * quo_ff);
         pb0_ff <= 33'(b0_ff * tc); pb1_ff <= 33'(b1_ff * quo_ff);
      end
      if (ctl.shift_up) begin
         pos_ff[ptr_ix] <= pos_ff[ptr_ix - IW'(1)];
         red_ff[ptr_ix] <= red_ff[ptr_ix - IW'(1)];
         grn_ff[ptr_ix] <= grn_ff[ptr_ix - IW'(1)];
         blu_ff[ptr_ix] <= blu_ff[ptr_ix - IW'(1)];
         opa_ff[ptr_ix] <= opa_ff[ptr_ix - IW'(1)];
      end else if (ctl.shift_down) begin
         pos_ff[ptr_ix] <= pos_ff[ptr_ix + IW'(1)];
         red_ff[ptr_ix] <= red_ff[ptr_ix + IW'(1)];
         grn_ff[ptr_ix] <= grn_ff[ptr_ix + IW'(1)];
         blu_ff[ptr_ix] <= blu_ff[ptr_ix + IW'(1)];
         opa_ff[ptr_ix] <= opa_ff[ptr_ix + IW'(1)];
      end else if (ctl.write_new) begin
         pos_ff[slot_ix] <= val_ff;
         red_ff[slot_ix] <= ro_ff;
         grn_ff[slot_ix] <= go_ff;
         blu_ff[slot_ix] <= bo_ff;
         opa_ff[slot_ix] <= opa_in_ff;
      end
   end

   always_comb begin
      sts.is_remove = op_ff;
      sts.empty = (cnt_ff == '0);
      sts.full = (cnt_ff == CW'(N));
      sts.bad_slot = ({1'b0, idx_ff} >= 5'(cnt_ff));
      sts.scan_done = found_ff;
      sts.shift_done = op_ff ? (ptr_ff + CW'(1) >= cnt_ff) : (ptr_ff <= slot_ff);
      sts.div_done = (dcnt_ff == 5'd0);
      sts.at_front = (slot_ff == '0);
      sts.at_end = (slot_ff == cnt_ff);
   end

   assign slot_out = op_ff ? IW'(idx_ff) : slot_ix;
   assign count_out = cnt_ff;
   assign red_out = ro_ff;
   assign green_out = go_ff;
   assign blue_out = bo_ff;
endmodule

// ----- hdl/scpt_control.sv -----
// Controller state machine of the sorted control point table.
module scpt_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output scpt_pkg::ctl_type ctl,
   input  scpt_pkg::sts_type sts
);
   typedef enum logic [3:0] {
      IDLE, CHECK, SCAN, PICK, DIV, MUL, SUM, SHIFT_UP, WRITE, SHIFT_DOWN, DONE
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] status_ff, status_in;

   always_comb begin
      ctl = '0;
      state_in = state_ff;
      status_in = status_ff;
      unique case (state_ff)
         IDLE: if (req_valid) begin
            ctl.load = 1'b1;
            state_in = CHECK;
         end
         CHECK: begin
            status_in = scpt_pkg::ST_DONE;
            if (sts.is_remove) begin
               if (sts.bad_slot) begin
                  status_in = scpt_pkg::ST_BAD_SLOT;
                  state_in = DONE;
               end else state_in = SHIFT_DOWN;
            end else if (sts.full) begin
               status_in = scpt_pkg::ST_FULL;
               state_in = DONE;
            end else state_in = SCAN;
         end
         SCAN: begin
            ctl.scan = 1'b1;
            if (sts.scan_done) state_in = PICK;
         end
         PICK: begin
            priority if (sts.empty) begin
               ctl.gray = 1'b1; state_in = SHIFT_UP;
            end else if (sts.at_front) begin
               ctl.copy_lo = 1'b1; state_in = SHIFT_UP;
            end else if (sts.at_end) begin
               ctl.copy_hi = 1'b1; state_in = SHIFT_UP;
            end else begin
               ctl.div_start = 1'b1; state_in = DIV;
            end
         end
         DIV: begin
            if (sts.div_done) state_in = MUL;
            else ctl.div_step = 1'b1;
         end
         MUL: begin
            ctl.blend_mul = 1'b1; state_in = SUM;
         end
         SUM: begin
            ctl.blend_sum = 1'b1; state_in = SHIFT_UP;
         end
         SHIFT_UP: begin
            if (sts.shift_done) state_in = WRITE;
            else ctl.shift_up = 1'b1;
         end
         WRITE: begin
            ctl.write_new = 1'b1; ctl.cnt_inc = 1'b1; state_in = DONE;
         end
         SHIFT_DOWN: begin
            if (sts.shift_done) begin
               ctl.cnt_dec = 1'b1; state_in = DONE;
            end else ctl.shift_down = 1'b1;
         end
         DONE: if (!rsp_stall) state_in = IDLE;
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         status_ff <= scpt_pkg::ST_DONE;
      end else begin
         state_ff <= state_in;
         status_ff <= status_in;
      end
   end

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = (state_ff == DONE);
   assign rsp_status = status_ff;

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall)) else $error("result shown while idle");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == PICK && ctl.div_start) |=> (state_ff == DIV))
      else $error("divider not started");
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");
endmodule

// ----- hdl/sorted_control_point_table.sv -----
// Top level of the sorted control point table.
// Sequential: one word at a time; an add uses the 16-step serial divide when
// interpolating between two points, and both adds and removes shift the entries in use.
// The shifts move one entry per cycle and the divider retires one quotient bit per cycle.
// Synchronous active-high reset empties the table; entry contents are left as they are.
module sorted_control_point_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [15:0] req_point_value,
   input  logic [15:0] req_point_opacity,
   input  logic [3:0]  req_slot_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_slot,
   output logic [4:0]  rsp_point_count,
   output logic [15:0] rsp_red,
   output logic [15:0] rsp_green,
   output logic [15:0] rsp_blue
);
   scpt_pkg::ctl_type ctl;
   scpt_pkg::sts_type sts;
   logic [scpt_pkg::IdxW-1:0] slot_w;
   logic [scpt_pkg::CntW-1:0] cnt_w;

   scpt_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_status,
      .ctl, .sts
   );

   scpt_datapath u_dp (
      .clock, .reset, .ctl, .sts, .req_op, .req_point_value, .req_point_opacity,
      .req_slot_index, .slot_out(slot_w), .count_out(cnt_w),
      .red_out(rsp_red), .green_out(rsp_green), .blue_out(rsp_blue)
   );

   assign rsp_slot = (rsp_status == scpt_pkg::ST_DONE) ? 4'(slot_w) : 4'd0;
   assign rsp_point_count = 5'(cnt_w);
endmodule
